>>> sv/gpio_pkg.sv
// Shared types and constants for the GPIO port with pin interrupts.
// Used by gpio_core, gpio_port_with_pin_interrupts and the testbench.
package gpio_pkg;

  localparam int unsigned PIN_COUNT_DEF = 32;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned HALF_PINS     = 16;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    REG_DATA      = 3'd0,
    REG_DIRECTION = 3'd1,
    REG_COND_LOW  = 3'd2,
    REG_COND_HIGH = 3'd3,
    REG_MASK      = 3'd4,
    REG_STATUS    = 3'd5,
    REG_BOTH_EDGE = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    COND_LOW     = 2'd0,
    COND_HIGH    = 2'd1,
    COND_RISING  = 2'd2,
    COND_FALLING = 2'd3
  } cond_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [2:0]        reg_index;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] pad_levels;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [WORD_W-1:0] pin_drive;
    logic [WORD_W-1:0] pin_output_enable;
    logic              irq_low_pins;
    logic              irq_high_pins;
  } result_t;

endpackage

>>> sv/gpio_core.sv
// GPIO register file, pin condition detection and result formation.
// Depends on gpio_pkg.
module gpio_core #(
  parameter int unsigned PIN_COUNT = gpio_pkg::PIN_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  gpio_pkg::item_t   item_i,
  output gpio_pkg::result_t result_o
);

  logic [PIN_COUNT-1:0]        data_q, data_d;
  logic [PIN_COUNT-1:0]        dir_q, dir_d;
  logic [PIN_COUNT-1:0]        mask_q, mask_d;
  logic [PIN_COUNT-1:0]        status_q, status_d;
  logic [PIN_COUNT-1:0]        both_q, both_d;
  logic [PIN_COUNT-1:0]        last_q, last_d;
  logic [gpio_pkg::WORD_W-1:0] cond_low_q, cond_low_d;
  logic [gpio_pkg::WORD_W-1:0] cond_high_q, cond_high_d;
  logic [2*gpio_pkg::WORD_W-1:0] cond_all;
  logic [PIN_COUNT-1:0]        hit;
  logic [PIN_COUNT-1:0]        pads;
  logic [PIN_COUNT-1:0]        wdata;
  logic [gpio_pkg::WORD_W-1:0] rdata;
  logic [gpio_pkg::WORD_W-1:0] pend;

  assign cond_all = {cond_high_q, cond_low_q};
  assign pads     = item_i.pad_levels[PIN_COUNT-1:0];
  assign wdata    = item_i.write_data[PIN_COUNT-1:0];

  for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
    logic [1:0] cond;
    logic       now, was;
    assign cond = cond_all[2*p +: 2];
    assign now  = pads[p];
    assign was  = last_q[p];
    always_comb begin
      if (both_q[p]) begin
        hit[p] = now ^ was;
      end else begin
        case (gpio_pkg::cond_e'(cond))
          gpio_pkg::COND_LOW:     hit[p] = !now;
          gpio_pkg::COND_HIGH:    hit[p] = now;
          gpio_pkg::COND_RISING:  hit[p] = now && !was;
          gpio_pkg::COND_FALLING: hit[p] = !now && was;
          default:                hit[p] = 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    data_d      = data_q;
    dir_d       = dir_q;
    mask_d      = mask_q;
    status_d    = status_q;
    both_d      = both_q;
    last_d      = last_q;
    cond_low_d  = cond_low_q;
    cond_high_d = cond_high_q;
    rdata       = '0;
    case (gpio_pkg::op_e'(item_i.opcode))
      gpio_pkg::OP_WRITE: begin
        case (gpio_pkg::reg_e'(item_i.reg_index))
          gpio_pkg::REG_DATA:      data_d      = wdata;
          gpio_pkg::REG_DIRECTION: dir_d       = wdata;
          gpio_pkg::REG_COND_LOW:  cond_low_d  = item_i.write_data;
          gpio_pkg::REG_COND_HIGH: cond_high_d = item_i.write_data;
          gpio_pkg::REG_MASK:      mask_d      = wdata;
          gpio_pkg::REG_STATUS:    status_d    = status_q & ~wdata;
          gpio_pkg::REG_BOTH_EDGE: both_d      = wdata;
          default: ;
        endcase
      end
      gpio_pkg::OP_READ: begin
        case (gpio_pkg::reg_e'(item_i.reg_index))
          gpio_pkg::REG_DATA:
            rdata = gpio_pkg::WORD_W'((data_q & dir_q) | (last_q & ~dir_q));
          gpio_pkg::REG_DIRECTION: rdata = gpio_pkg::WORD_W'(dir_q);
          gpio_pkg::REG_COND_LOW:  rdata = cond_low_q;
          gpio_pkg::REG_COND_HIGH: rdata = cond_high_q;
          gpio_pkg::REG_MASK:      rdata = gpio_pkg::WORD_W'(mask_q);
          gpio_pkg::REG_STATUS:    rdata = gpio_pkg::WORD_W'(status_q);
          gpio_pkg::REG_BOTH_EDGE: rdata = gpio_pkg::WORD_W'(both_q);
          default:                 rdata = '0;
        endcase
      end
      gpio_pkg::OP_SAMPLE: begin
        status_d = status_q | hit;
        last_d   = pads;
      end
      default: ;
    endcase
  end

  assign pend = gpio_pkg::WORD_W'(status_d & mask_d);

  always_comb begin
    result_o.read_data         = rdata;
    result_o.pin_drive         = gpio_pkg::WORD_W'(data_d & dir_d);
    result_o.pin_output_enable = gpio_pkg::WORD_W'(dir_d);
    result_o.irq_low_pins      = |pend[gpio_pkg::HALF_PINS-1:0];
    result_o.irq_high_pins     = |pend[gpio_pkg::WORD_W-1:gpio_pkg::HALF_PINS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q      <= '0;
      dir_q       <= '0;
      mask_q      <= '0;
      status_q    <= '0;
      both_q      <= '0;
      last_q      <= '0;
      cond_low_q  <= '0;
      cond_high_q <= '0;
    end else if (fire_i) begin
      data_q      <= data_d;
      dir_q       <= dir_d;
      mask_q      <= mask_d;
      status_q    <= status_d;
      both_q      <= both_d;
      last_q      <= last_d;
      cond_low_q  <= cond_low_d;
      cond_high_q <= cond_high_d;
    end
  end

endmodule

>>> sv/gpio_port_with_pin_interrupts.sv
// Top level of the GPIO port: input stage, gpio_core and result register.
// Depends on gpio_pkg and gpio_core.
// Each item is held in the input stage register, then its result in the result register.
// Throughput: one item per cycle; the input stage advances whenever the
// result register is empty or being drained in the same cycle.
// Reset (async, active low) clears state and valid flags: pins are inputs, all masked.
module gpio_port_with_pin_interrupts #(
  parameter int unsigned PIN_COUNT = gpio_pkg::PIN_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [2:0]  reg_index_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] pad_levels_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic [31:0] pin_drive_o,
  output logic [31:0] pin_output_enable_o,
  output logic        irq_low_pins_o,
  output logic        irq_high_pins_o
);

  logic              item_vld_q;
  gpio_pkg::item_t   item_q;
  logic              res_vld_q;
  gpio_pkg::result_t res_q, res_d;
  logic              advance;
  logic              fire;

  assign advance    = !res_vld_q || out_ready_i;
  assign fire       = item_vld_q && advance;
  assign in_ready_o = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{opcode:     opcode_i,
                  reg_index:  reg_index_i,
                  write_data: write_data_i,
                  pad_levels: pad_levels_i};
    end
  end

  gpio_core #(
    .PIN_COUNT(PIN_COUNT)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (item_q),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = res_vld_q;
  assign read_data_o         = res_q.read_data;
  assign pin_drive_o         = res_q.pin_drive;
  assign pin_output_enable_o = res_q.pin_output_enable;
  assign irq_low_pins_o      = res_q.irq_low_pins;
  assign irq_high_pins_o     = res_q.irq_high_pins;

endmodule

>>> sv/gpio_checker.sv
// Port-level assertions for the GPIO port, bound to the top level.
// Depends on gpio_port_with_pin_interrupts.
module gpio_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  opcode_i,
  input logic [31:0] write_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] read_data_o,
  input logic [31:0] pin_drive_o,
  input logic [31:0] pin_output_enable_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(opcode_i) && $stable(write_data_i))
    else $error("input transfer dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o)
      && $stable(pin_drive_o) && $stable(pin_output_enable_o))
    else $error("result changed while stalled");

  a_drive_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pin_drive_o & ~pin_output_enable_o) == 32'd0)
    else $error("pin driven while not an output");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

bind gpio_port_with_pin_interrupts gpio_checker u_gpio_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .opcode_i           (opcode_i),
  .write_data_i       (write_data_i),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .read_data_o        (read_data_o),
  .pin_drive_o        (pin_drive_o),
  .pin_output_enable_o(pin_output_enable_o)
);

>>> tb/testbench.sv
// Self-checking testbench for gpio_port_with_pin_interrupts: register access, pad sampling,
// interrupt detection and the two interrupt lines, checked against an in-bench predictor.
// Depends on gpio_pkg and the RTL of the GPIO port.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned PINS          = gpio_pkg::PIN_COUNT_DEF;
  localparam logic [31:0] PIN_MASK      =
    (PINS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << PINS) - 32'd1);
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [2:0]  REG_UNUSED    = 3'd7;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES  = 30;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  opcode_i;
  logic [2:0]  reg_index_i;
  logic [31:0] write_data_i;
  logic [31:0] pad_levels_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] read_data_o;
  logic [31:0] pin_drive_o;
  logic [31:0] pin_output_enable_o;
  logic        irq_low_pins_o;
  logic        irq_high_pins_o;

  gpio_port_with_pin_interrupts dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .opcode_i            (opcode_i),
    .reg_index_i         (reg_index_i),
    .write_data_i        (write_data_i),
    .pad_levels_i        (pad_levels_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .read_data_o         (read_data_o),
    .pin_drive_o         (pin_drive_o),
    .pin_output_enable_o (pin_output_enable_o),
    .irq_low_pins_o      (irq_low_pins_o),
    .irq_high_pins_o     (irq_high_pins_o)
  );

  // predicted register file
  logic [31:0] data_q, dir_q, cond_lo_q, cond_hi_q, mask_q, status_q, both_q, pads_q;

  gpio_pkg::result_t gpio_results_q[$];
  int unsigned errors;
  int unsigned idle_cycles;
  bit          send_idle_en;
  bit          sink_stall_en;
  logic [31:0] last_pads_sent;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  task automatic gpio_step(input logic [1:0] op, input logic [2:0] idx,
                           input logic [31:0] wdata, input logic [31:0] pads);
    gpio_pkg::result_t r;
    logic [31:0] hit;
    logic [31:0] pend;
    logic [31:0] p_pads;
    logic [1:0]  code;
    logic        now_b, was_b, trig;
    r = '0;
    case (op)
      gpio_pkg::OP_WRITE: begin
        case (idx)
          gpio_pkg::REG_DATA:      data_q = wdata & PIN_MASK;
          gpio_pkg::REG_DIRECTION: dir_q = wdata & PIN_MASK;
          gpio_pkg::REG_COND_LOW:  cond_lo_q = wdata;
          gpio_pkg::REG_COND_HIGH: cond_hi_q = wdata;
          gpio_pkg::REG_MASK:      mask_q = wdata & PIN_MASK;
          gpio_pkg::REG_STATUS:    status_q = status_q & ~wdata;
          gpio_pkg::REG_BOTH_EDGE: both_q = wdata & PIN_MASK;
          default: ;
        endcase
      end
      gpio_pkg::OP_READ: begin
        case (idx)
          gpio_pkg::REG_DATA:      r.read_data = (data_q & dir_q) | (pads_q & ~dir_q);
          gpio_pkg::REG_DIRECTION: r.read_data = dir_q;
          gpio_pkg::REG_COND_LOW:  r.read_data = cond_lo_q;
          gpio_pkg::REG_COND_HIGH: r.read_data = cond_hi_q;
          gpio_pkg::REG_MASK:      r.read_data = mask_q;
          gpio_pkg::REG_STATUS:    r.read_data = status_q;
          gpio_pkg::REG_BOTH_EDGE: r.read_data = both_q;
          default:                 r.read_data = '0;
        endcase
      end
      gpio_pkg::OP_SAMPLE: begin
        hit = '0;
        p_pads = pads & PIN_MASK;
        for (int p = 0; p < 32; p++) begin
          if (p < PINS) begin
            now_b = p_pads[p];
            was_b = pads_q[p];
            code = (p < gpio_pkg::HALF_PINS) ? cond_lo_q[2*p +: 2]
                                             : cond_hi_q[2*(p-gpio_pkg::HALF_PINS) +: 2];
            if (both_q[p]) begin
              trig = now_b != was_b;
            end else begin
              case (code)
                gpio_pkg::COND_LOW:    trig = !now_b;
                gpio_pkg::COND_HIGH:   trig = now_b;
                gpio_pkg::COND_RISING: trig = now_b && !was_b;
                default:               trig = !now_b && was_b;
              endcase
            end
            hit[p] = trig;
          end
        end
        status_q = status_q | hit;
        pads_q = p_pads;
      end
      default: ;
    endcase
    pend = status_q & mask_q;
    r.pin_drive = data_q & dir_q;
    r.pin_output_enable = dir_q;
    r.irq_low_pins = |pend[15:0];
    r.irq_high_pins = |pend[31:16];
    gpio_results_q.push_back(r);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [1:0] op, input logic [2:0] idx,
                           input logic [31:0] wdata, input logic [31:0] pads);
    int unsigned gap;
    gap = send_idle_en ? idle_length() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    reg_index_i  <= idx;
    write_data_i <= wdata;
    pad_levels_i <= pads;
    do @(posedge clk_i); while (!in_ready_o);
    gpio_step(op, idx, wdata, pads);
    if (op == gpio_pkg::OP_SAMPLE) last_pads_sent = pads;
    @(negedge clk_i);
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    gpio_pkg::result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (gpio_results_q.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected", $time);
      end else begin
        exp_r = gpio_results_q.pop_front();
        compare_field("read_data", exp_r.read_data, read_data_o);
        compare_field("pin_drive", exp_r.pin_drive, pin_drive_o);
        compare_field("pin_output_enable", exp_r.pin_output_enable, pin_output_enable_o);
        compare_field("irq_low_pins", {31'd0, exp_r.irq_low_pins}, {31'd0, irq_low_pins_o});
        compare_field("irq_high_pins", {31'd0, exp_r.irq_high_pins}, {31'd0, irq_high_pins_o});
      end
    end
  end

  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) hold--;
      else if (sink_stall_en && $urandom_range(0, 3) == 0) hold = idle_length();
      out_ready_i <= (hold == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] next_pads();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2, 3:    return last_pads_sent ^ (32'd1 << $urandom_range(0, 31));
      4:       return last_pads_sent ^ ($urandom & $urandom);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_state();
    for (int i = 0; i < 8; i++) send_item(gpio_pkg::OP_READ, 3'(i), $urandom, $urandom);
  endtask

  task automatic test_output_pins();
    send_item(gpio_pkg::OP_WRITE, gpio_pkg::REG_DIRECTION, 32'hFFFF_0000, '0);
    send_item(gpio_pkg::OP_WRITE, gpio_pkg::REG_DATA, 32'hFFFF_FFFF, '1);
    send_item(gpio_pkg::OP_SAMPLE, gpio_pkg::REG_DATA, '0, 32'h0000_FFFF);
    send_item(gpio_pkg::OP_READ, gpio_pkg::REG_DATA, '0, '0);
    send_item(gpio_pkg::OP_WRITE, gpio_pkg::REG_DIRECTION, 32'hFFFF_FFFF, '0);
  endtask

  task automatic test_pin_conditions();
    // in the low half the pin conditions repeat low, high, rising, falling; in the high half falling, rising, high, low
    send_item(gpio_pkg::OP_WRITE, gpio_pkg::REG_COND_LOW, 32'hE4E4_E4E4, '0);
    send_item(gpio_pkg::OP_WRITE, gpio_pkg::REG_COND_HIGH, 32'h1B1B_1B1B, '0);
    send_item(gpio_pkg::OP_WRITE, gpio_pkg::REG_MASK, 32'hFFFF_FFFF, '0);
    send_item(gpio_pkg::OP_SAMPLE, gpio_pkg::REG_DATA, '0, 32'hFFFF_FFFF);
    send_item(gpio_pkg::OP_SAMPLE, gpio_pkg::REG_DATA, '0, 32'h0000_0000);
    send_item(gpio_pkg::OP_WRITE, gpio_pkg::REG_STATUS, 32'hFFFF_FFFF, '0);
    send_item(gpio_pkg::OP_SAMPLE, gpio_pkg::REG_DATA, '0, 32'h0000_0000);
    send_item(gpio_pkg::OP_READ, gpio_pkg::REG_STATUS, '0, '0);
    send_item(gpio_pkg::OP_WRITE, gpio_pkg::REG_BOTH_EDGE, 32'hAAAA_AAAA, '0);
    send_item(gpio_pkg::OP_SAMPLE, gpio_pkg::REG_DATA, '0, 32'h5555_5555);
    send_item(gpio_pkg::OP_READ, gpio_pkg::REG_STATUS, '0, '0);
  endtask

  task automatic test_unused_codes();
    send_item(OP_UNUSED, gpio_pkg::REG_STATUS, '1, '1);
    send_item(gpio_pkg::OP_WRITE, REG_UNUSED, '1, '0);
    send_item(gpio_pkg::OP_READ, REG_UNUSED, '0, '0);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned r;
    logic [2:0]  idx;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      idx = 3'($urandom_range(0, 7));
      if (r < 40)      send_item(gpio_pkg::OP_SAMPLE, idx, $urandom, next_pads());
      else if (r < 72) send_item(gpio_pkg::OP_WRITE, idx, rand_word(), $urandom);
      else if (r < 95) send_item(gpio_pkg::OP_READ, idx, $urandom, $urandom);
      else             send_item(OP_UNUSED, idx, $urandom, $urandom);
    end
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    send_idle_en = 1'b1;
    sink_stall_en = 1'b1;
    last_pads_sent = '0;
    {data_q, dir_q, cond_lo_q, cond_hi_q, mask_q, status_q, both_q, pads_q} = '0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = gpio_pkg::OP_WRITE;
    reg_index_i = gpio_pkg::REG_DATA;
    write_data_i = '0;
    pad_levels_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_output_pins();
    test_pin_conditions();
    test_unused_codes();

    test_random_traffic(200);
    send_idle_en = 1'b0;
    sink_stall_en = 1'b0;
    test_random_traffic(150);
    send_idle_en = 1'b1;
    test_random_traffic(130);
    send_idle_en = 1'b0;
    sink_stall_en = 1'b1;
    test_random_traffic(130);
    send_idle_en = 1'b1;
    test_random_traffic(140);

    in_valid_i <= 1'b0;
    while (gpio_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> gpio_port_with_pin_interrupts.f
sv/gpio_pkg.sv
sv/gpio_core.sv
sv/gpio_port_with_pin_interrupts.sv
sv/gpio_checker.sv
tb/testbench.sv
